/* design/gtm_pkg.sv */
// shared types and constants for the gesture template matcher
`timescale 1ns / 1ps

package gtm_pkg;

  // gesture length saturation and number of computed features
  localparam int unsigned MaxSamples  = 1024;
  localparam int unsigned NumFeatures = 2;
  localparam int unsigned CountW      = 11;
  localparam int unsigned DevW        = 15;
  localparam logic [DevW-1:0] DevSat  = 15'h7fff;

  // apb address and data widths
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // width of the relaxed window bounds
  localparam int unsigned BoundW = 18;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegOneG      = 3'd0,
    RegDurLow    = 3'd1,
    RegDurHigh   = 3'd2,
    RegDevLow    = 3'd3,
    RegDevHigh   = 3'd4,
    RegDimsUsed  = 3'd5,
    RegTplLoaded = 3'd6
  } reg_idx_e;

  // one accelerometer sample
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               last_sample;
  } in_item_t;

  // one gesture result
  typedef struct packed {
    logic              match;
    logic [CountW-1:0] sample_count;
    logic [DevW-1:0]   peak_deviation;
  } out_item_t;

endpackage

/* design/gtm_sumsq.sv */
// bit-serial sum of squares of three 16-bit magnitudes
`timescale 1ns / 1ps

module gtm_sumsq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic [15:0] z_i,
  output logic        done_o,
  output logic [31:0] sum_o
);

  logic [15:0] mx_q, my_q, mz_q;
  logic [15:0] bx_q, by_q, bz_q;
  logic [16:0] acc_hi_q;
  logic [15:0] lo_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [17:0] step_sum;

  // three partial products for the current multiplier bit
  assign step_sum = {1'b0, acc_hi_q}
                  + (bx_q[0] ? {2'b00, mx_q} : 18'd0)
                  + (by_q[0] ? {2'b00, my_q} : 18'd0)
                  + (bz_q[0] ? {2'b00, mz_q} : 18'd0);

  // shift-add sequencer, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      acc_hi_q <= '0;
      lo_q     <= '0;
      mx_q     <= '0;
      my_q     <= '0;
      mz_q     <= '0;
      bx_q     <= '0;
      by_q     <= '0;
      bz_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        acc_hi_q <= '0;
        lo_q     <= '0;
        mx_q     <= x_i;
        my_q     <= y_i;
        mz_q     <= z_i;
        bx_q     <= x_i;
        by_q     <= y_i;
        bz_q     <= z_i;
      end else if (busy_q) begin
        acc_hi_q <= step_sum[17:1];
        lo_q     <= {step_sum[0], lo_q[15:1]};
        bx_q     <= {1'b0, bx_q[15:1]};
        by_q     <= {1'b0, by_q[15:1]};
        bz_q     <= {1'b0, bz_q[15:1]};
        cnt_q    <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = {acc_hi_q[15:0], lo_q};

endmodule

/* design/gtm_isqrt.sv */
// digit-by-digit floor square root, one root bit per cycle
`timescale 1ns / 1ps

module gtm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] radicand_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic [31:0] rad_q;
  logic [16:0] rem_q;
  logic [15:0] root_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [18:0] shifted;
  logic [18:0] trial;
  logic [18:0] diff;
  logic        fits;

  // bring down the next two radicand bits and try a one digit
  assign shifted = {rem_q, rad_q[31:30]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign fits    = shifted >= trial;
  assign diff    = shifted - trial;

  // restoring root sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q <= {rad_q[29:0], 2'b00};
        if (fits) begin
          rem_q  <= diff[16:0];
          root_q <= {root_q[14:0], 1'b1};
        end else begin
          rem_q  <= shifted[16:0];
          root_q <= {root_q[14:0], 1'b0};
        end
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/gesture_template_matcher_top.sv */
// gesture template matcher: per-sample magnitude features and template check
// an accepted sample runs through the bit-serial square sum, then the digit-by-digit
// square root, then an update step that waits while an unread result is stalled;
// a gesture's result is loaded after its last sample; the sample stall stays high until idle
// a finished result waits in the output register while the next sample is taken
// reset: asynchronous active low, clears config registers, features and output; window bounds are not reset
`timescale 1ns / 1ps

module gesture_template_matcher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gtm_pkg::in_item_t             in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gtm_pkg::out_item_t            out_data_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtm_pkg::AddrW-1:0]     paddr,
  input  logic [gtm_pkg::DataW-1:0]     pwdata,
  output logic [gtm_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    StIdle,
    StSquare,
    StRoot,
    StUpdate
  } state_e;

  localparam int unsigned BW = gtm_pkg::BoundW;
  localparam int unsigned CW = gtm_pkg::CountW;
  localparam int unsigned DW = gtm_pkg::DevW;

  // configuration registers
  logic [14:0]        one_g_q;
  logic [15:0]        dur_low_q;
  logic [15:0]        dur_high_q;
  logic signed [15:0] dev_low_q;
  logic signed [15:0] dev_high_q;
  logic [1:0]         dims_q;
  logic               loaded_q;

  logic              cfg_wr;
  gtm_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = gtm_pkg::reg_idx_e'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_g_q    <= '0;
      dur_low_q  <= '0;
      dur_high_q <= '0;
      dev_low_q  <= '0;
      dev_high_q <= '0;
      dims_q     <= '0;
      loaded_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gtm_pkg::RegOneG:      one_g_q    <= pwdata[14:0];
        gtm_pkg::RegDurLow:    dur_low_q  <= pwdata[15:0];
        gtm_pkg::RegDurHigh:   dur_high_q <= pwdata[15:0];
        gtm_pkg::RegDevLow:    dev_low_q  <= pwdata[15:0];
        gtm_pkg::RegDevHigh:   dev_high_q <= pwdata[15:0];
        gtm_pkg::RegDimsUsed:  dims_q     <= pwdata[1:0];
        gtm_pkg::RegTplLoaded: loaded_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      gtm_pkg::RegOneG:      prdata = {17'd0, one_g_q};
      gtm_pkg::RegDurLow:    prdata = {16'd0, dur_low_q};
      gtm_pkg::RegDurHigh:   prdata = {16'd0, dur_high_q};
      gtm_pkg::RegDevLow:    prdata = {{16{dev_low_q[15]}}, dev_low_q};
      gtm_pkg::RegDevHigh:   prdata = {{16{dev_high_q[15]}}, dev_high_q};
      gtm_pkg::RegDimsUsed:  prdata = {30'd0, dims_q};
      gtm_pkg::RegTplLoaded: prdata = {31'd0, loaded_q};
      default:               prdata = '0;
    endcase
  end

  // relaxed window bounds, widened by half the range rounded down
  logic signed [BW-1:0] dur_lo_ext, dur_hi_ext, dev_lo_ext, dev_hi_ext;
  logic signed [BW-1:0] dur_margin, dev_margin;
  logic signed [BW-1:0] dur_lo_b_q, dur_hi_b_q, dev_lo_b_q, dev_hi_b_q;

  assign dur_lo_ext = $signed({2'b00, dur_low_q});
  assign dur_hi_ext = $signed({2'b00, dur_high_q});
  assign dev_lo_ext = $signed({{2{dev_low_q[15]}}, dev_low_q});
  assign dev_hi_ext = $signed({{2{dev_high_q[15]}}, dev_high_q});
  assign dur_margin = (dur_hi_ext - dur_lo_ext) >>> 1;
  assign dev_margin = (dev_hi_ext - dev_lo_ext) >>> 1;

  always_ff @(posedge clk_i) begin
    dur_lo_b_q <= dur_lo_ext - dur_margin;
    dur_hi_b_q <= dur_hi_ext + dur_margin;
    dev_lo_b_q <= dev_lo_ext - dev_margin;
    dev_hi_b_q <= dev_hi_ext + dev_margin;
  end

  // sample magnitudes
  logic        in_accept;
  logic [15:0] abs_x, abs_y, abs_z;

  assign abs_x = in_data_i.accel_x[15] ? 16'(~in_data_i.accel_x + 16'sd1)
                                       : in_data_i.accel_x;
  assign abs_y = in_data_i.accel_y[15] ? 16'(~in_data_i.accel_y + 16'sd1)
                                       : in_data_i.accel_y;
  assign abs_z = in_data_i.accel_z[15] ? 16'(~in_data_i.accel_z + 16'sd1)
                                       : in_data_i.accel_z;

  // serial arithmetic units
  logic        sq_done;
  logic [31:0] sq_sum;
  logic        rt_done;
  logic [15:0] rt_root;

  gtm_sumsq u_sumsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .x_i     (abs_x),
    .y_i     (abs_y),
    .z_i     (abs_z),
    .done_o  (sq_done),
    .sum_o   (sq_sum)
  );

  gtm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_done),
    .radicand_i (sq_sum),
    .done_o     (rt_done),
    .root_o     (rt_root)
  );

  // deviation of the magnitude from one g, saturated
  logic [15:0] mag_diff;
  logic [DW-1:0] dev_sat;

  assign mag_diff = (rt_root >= {1'b0, one_g_q}) ? rt_root - {1'b0, one_g_q}
                                                 : {1'b0, one_g_q} - rt_root;
  assign dev_sat  = (mag_diff > {1'b0, gtm_pkg::DevSat}) ? gtm_pkg::DevSat
                                                         : mag_diff[DW-1:0];

  // feature update and template check
  state_e             state_q;
  logic               last_q;
  logic [DW-1:0]      dev_q;
  logic [CW-1:0]      count_q;
  logic [DW-1:0]      peak_q;
  logic               out_valid_q;
  gtm_pkg::out_item_t out_data_q;

  logic [CW-1:0] new_count;
  logic [DW-1:0] new_peak;
  logic [1:0]    dims_eff;
  logic          dur_ok, dev_ok, match;
  logic          out_blocked;
  logic          out_load;

  assign new_count = (count_q < CW'(gtm_pkg::MaxSamples)) ? count_q + CW'(1) : count_q;
  assign new_peak  = (dev_q > peak_q) ? dev_q : peak_q;
  assign dims_eff  = ({30'd0, dims_q} > gtm_pkg::NumFeatures) ? 2'(gtm_pkg::NumFeatures)
                                                               : dims_q;
  assign dur_ok = ($signed({{(BW-CW){1'b0}}, new_count}) >= dur_lo_b_q)
                & ($signed({{(BW-CW){1'b0}}, new_count}) <= dur_hi_b_q);
  assign dev_ok = ($signed({{(BW-DW){1'b0}}, new_peak}) >= dev_lo_b_q)
                & ($signed({{(BW-DW){1'b0}}, new_peak}) <= dev_hi_b_q);
  assign match  = loaded_q & ((dims_eff < 2'd1) | dur_ok) & ((dims_eff < 2'd2) | dev_ok);
  assign out_blocked = last_q & out_valid_q & out_stall_i;
  assign out_load    = (state_q == StUpdate) & last_q & ~out_blocked;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // sequencer, feature state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_q      <= 1'b0;
      dev_q       <= '0;
      count_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // a new result refills the output register as the old one leaves
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            last_q  <= in_data_i.last_sample;
            state_q <= StSquare;
          end
        end
        StSquare: begin
          if (sq_done) begin
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (rt_done) begin
            dev_q   <= dev_sat;
            state_q <= StUpdate;
          end
        end
        StUpdate: begin
          if (!out_blocked) begin
            state_q <= StIdle;
            if (last_q) begin
              out_data_q.match           <= match;
              out_data_q.sample_count    <= new_count;
              out_data_q.peak_deviation  <= new_peak;
              count_q                    <= '0;
              peak_q                     <= '0;
            end else begin
              count_q <= new_count;
              peak_q  <= new_peak;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
